// ----- hdl/mfld_pkg.sv -----
// Shared types and constants for the monochrome framebuffer line engine.
package mfld_pkg;

   localparam int COORD_W   = 10;
   localparam int ERR_W     = 13;
   localparam int IDX_W     = 13;
   localparam int WIDTH_W   = 8;
   localparam int HEIGHT_W  = 7;
   localparam int DATA_W    = 8;
   localparam int ADDR_IN_W = 10;
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   localparam logic [OP_W-1:0] OP_DRAW  = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_HEIGHT = 2'd1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 8'd128;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd64;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DRAW,
      ST_CLEAR,
      ST_READ,
      ST_FINISH
   } state_type;

   // one pixel from the line walker per cycle
   typedef struct packed {
      logic             hit;
      logic             last;
      logic [IDX_W-1:0] idx;
      logic [2:0]       bit_sel;
   } pix_type;

endpackage

// ----- hdl/mfld_if.sv -----
// Request and response channel interfaces of the framebuffer line engine.
interface mfld_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          operation;
   logic signed [9:0]   x_start;
   logic signed [9:0]   y_start;
   logic signed [9:0]   x_end;
   logic signed [9:0]   y_end;
   logic                color;
   logic [9:0]          byte_address;

   modport source (output valid, operation, x_start, y_start, x_end, y_end, color,
                   byte_address, input ready);
   modport sink (input valid, operation, x_start, y_start, x_end, y_end, color,
                 byte_address, output ready);
endinterface

interface mfld_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       done_res;

   modport source (output valid, read_data, done_res, input ready);
   modport sink (input valid, read_data, done_res, output ready);
endinterface

// ----- hdl/mfld_ram.sv -----
// Generic simple dual-port RAM, one write port and one registered read port.
module mfld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/mfld_line_walk.sv -----
// Bresenham line walker: one pixel position and its byte index per cycle.
module mfld_line_walk #(
   parameter int STORE_BYTES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [mfld_pkg::COORD_W-1:0] x_start,
   input  logic signed [mfld_pkg::COORD_W-1:0] y_start,
   input  logic signed [mfld_pkg::COORD_W-1:0] x_end,
   input  logic signed [mfld_pkg::COORD_W-1:0] y_end,
   input  logic [mfld_pkg::WIDTH_W-1:0]        width,
   input  logic [mfld_pkg::HEIGHT_W-1:0]       height,
   output mfld_pkg::pix_type                   pix
);
   import mfld_pkg::*;

   logic                      active_ff, active_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in, xe_ff, ye_ff;
   logic signed [COORD_W:0]   dx_ff, dy_ff;
   logic                      sx_neg_ff, sy_neg_ff;
   logic signed [ERR_W-1:0]   err_ff, err_in;

   logic signed [COORD_W:0]   diff_x, diff_y, abs_x, abs_y;
   logic signed [ERR_W:0]     e2;
   logic                      step_x, step_y, at_end;
   logic                      on_panel;
   logic [IDX_W-1:0]          idx;

   // load values
   assign diff_x = (COORD_W+1)'(x_end) - (COORD_W+1)'(x_start);
   assign diff_y = (COORD_W+1)'(y_end) - (COORD_W+1)'(y_start);
   assign abs_x  = diff_x[COORD_W] ? -diff_x : diff_x;
   assign abs_y  = diff_y[COORD_W] ? -diff_y : diff_y;

   // step decision
   assign e2     = (ERR_W+1)'(err_ff) <<< 1;
   assign step_x = e2 > -((ERR_W+1)'(dy_ff));
   assign step_y = e2 < (ERR_W+1)'(dx_ff);
   assign at_end = (x_ff == xe_ff) && (y_ff == ye_ff);

   always_comb begin
      active_in = active_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      err_in    = err_ff;
      if (start) begin
         active_in = 1'b1;
         x_in      = x_start;
         y_in      = y_start;
         err_in    = ERR_W'(abs_x) - ERR_W'(abs_y);
      end else if (active_ff) begin
         if (at_end) begin
            active_in = 1'b0;
         end else begin
            err_in = err_ff - (step_x ? ERR_W'(dy_ff) : '0) + (step_y ? ERR_W'(dx_ff) : '0);
            if (step_x) begin
               x_in = sx_neg_ff ? x_ff - COORD_W'(1) : x_ff + COORD_W'(1);
            end
            if (step_y) begin
               y_in = sy_neg_ff ? y_ff - COORD_W'(1) : y_ff + COORD_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      err_ff <= err_in;
      if (start) begin
         xe_ff     <= x_end;
         ye_ff     <= y_end;
         dx_ff     <= abs_x;
         dy_ff     <= abs_y;
         sx_neg_ff <= !(diff_x > 0);
         sy_neg_ff <= !(diff_y > 0);
      end
   end

   // panel clip and page address
   assign on_panel = !x_ff[COORD_W-1] && !y_ff[COORD_W-1]
                     && (x_ff[COORD_W-2:0] < (COORD_W-1)'(width))
                     && (y_ff[COORD_W-2:0] < (COORD_W-1)'(height));
   assign idx = IDX_W'(x_ff[WIDTH_W-1:0])
              + IDX_W'(y_ff[HEIGHT_W-1:3]) * IDX_W'(width);

   assign pix.hit     = active_ff && on_panel && (32'(idx) < 32'(STORE_BYTES));
   assign pix.last    = active_ff && at_end;
   assign pix.idx     = idx;
   assign pix.bit_sel = y_ff[2:0];

endmodule

// ----- hdl/mono_framebuffer_line_draw.sv -----
// Top level of the monochrome page framebuffer line engine.
//
// One request is worked at a time. A line request walks the Bresenham line one
// pixel per cycle through a read-modify-write on the pixel memory, which has a
// single write port and a registered read port. A clear request writes one
// zero byte per cycle over min(width*height/8, STORE_BYTES) bytes. Each result
// goes to the output register. After reset a clearing pass writes zeros over
// all STORE_BYTES bytes, one per cycle, and no request is accepted until it
// ends (configuration writes are taken throughout). A waiting result does not
// block the next request.
module mono_framebuffer_line_draw #(
   parameter int STORE_BYTES = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   mfld_req_if.sink                           req_if,
   mfld_rsp_if.source                         rsp_if,
   input  logic                               csr_we,
   input  logic [mfld_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mfld_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import mfld_pkg::*;

   localparam int AW = $clog2(STORE_BYTES);
   localparam int CW = $clog2(STORE_BYTES + 1);

   state_type            state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in, lim_ff, lim_in;
   logic [DATA_W-1:0]    res_data_ff, res_data_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic                 color_ff, color_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [WIDTH_W-1:0]   width_ff, width_in;
   logic [HEIGHT_W-1:0]  height_ff, height_in;

   // read-modify-write stage
   logic                 s1_valid_ff;
   logic [AW-1:0]        s1_addr_ff;
   logic [2:0]           s1_bit_ff;
   logic                 wr_valid_ff;
   logic [AW-1:0]        wr_addr_ff;
   logic [DATA_W-1:0]    wr_data_ff;

   logic                 req_ready, accept, walk_start, clear_we, rsp_free;
   pix_type              pix;
   logic [AW-1:0]        raddr, waddr;
   logic [DATA_W-1:0]    rdata, wdata, rmw_base, rmw_mask, rmw_data;
   logic                 we;
   logic [WIDTH_W+HEIGHT_W-1:0] area;
   logic [CW-1:0]        clr_lim;

   assign accept   = req_if.valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = req_ready;

   // bytes covered by the panel, capped at the store size
   assign area    = (WIDTH_W+HEIGHT_W)'(width_ff) * (WIDTH_W+HEIGHT_W)'(height_ff);
   assign clr_lim = (32'(area >> 3) > 32'(STORE_BYTES)) ? CW'(STORE_BYTES)
                                                       : CW'(area >> 3);

   // config registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PANEL_WIDTH:  width_in  = csr_wdata[WIDTH_W-1:0];
            CSR_PANEL_HEIGHT: height_in = csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (cnt_ff == lim_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_if.operation)
                  OP_DRAW:  state_in = ST_DRAW;
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_READ:  state_in = ST_READ;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end
         ST_DRAW: begin
            if (pix.last) state_in = ST_FINISH;
         end
         ST_CLEAR: begin
            if (cnt_ff == lim_ff) state_in = ST_FINISH;
         end
         ST_READ: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs and datapath controls
   always_comb begin
      req_ready    = 1'b0;
      walk_start   = 1'b0;
      clear_we     = 1'b0;
      cnt_in       = cnt_ff;
      lim_in       = lim_ff;
      res_data_in  = res_data_ff;
      rd_ok_in     = rd_ok_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            if (cnt_ff != lim_ff) begin
               clear_we = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               walk_start  = (req_if.operation == OP_DRAW);
               cnt_in      = '0;
               lim_in      = clr_lim;
               color_in    = req_if.color;
               res_data_in = '0;
               rd_ok_in    = 32'(req_if.byte_address) < 32'(STORE_BYTES);
            end
         end
         ST_READ: begin
            res_data_in = rd_ok_ff ? rdata : '0;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         lim_ff       <= CW'(STORE_BYTES);
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         s1_valid_ff  <= 1'b0;
         wr_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         lim_ff       <= lim_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         s1_valid_ff  <= pix.hit;
         wr_valid_ff  <= s1_valid_ff;
      end
      res_data_ff <= res_data_in;
      rd_ok_ff    <= rd_ok_in;
      color_ff    <= color_in;
      rsp_data_ff <= rsp_data_in;
      s1_addr_ff  <= AW'(pix.idx);
      s1_bit_ff   <= pix.bit_sel;
      wr_addr_ff  <= s1_addr_ff;
      wr_data_ff  <= rmw_data;
   end

   mfld_line_walk #(
      .STORE_BYTES(STORE_BYTES)
   ) u_walk (
      .clock   (clock),
      .reset   (reset),
      .start   (walk_start),
      .x_start (req_if.x_start),
      .y_start (req_if.y_start),
      .x_end   (req_if.x_end),
      .y_end   (req_if.y_end),
      .width   (width_ff),
      .height  (height_ff),
      .pix     (pix)
   );

   // pixel read is issued as the walker shows it; the write follows from the s1 stage.
   // Back-to-back hits on one byte read stale data, so take the last write.
   assign raddr    = (state_ff == ST_DRAW) ? AW'(pix.idx) : AW'(req_if.byte_address);
   assign rmw_base = (wr_valid_ff && (wr_addr_ff == s1_addr_ff)) ? wr_data_ff : rdata;
   assign rmw_mask = DATA_W'(1) << s1_bit_ff;
   assign rmw_data = color_ff ? (rmw_base | rmw_mask) : (rmw_base & ~rmw_mask);

   assign we    = s1_valid_ff || clear_we;
   assign waddr = clear_we ? AW'(cnt_ff) : s1_addr_ff;
   assign wdata = clear_we ? '0 : rmw_data;

   mfld_ram #(
      .WIDTH(DATA_W),
      .DEPTH(STORE_BYTES)
   ) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.read_data = rsp_data_ff;
   assign rsp_if.done_res  = 1'b1;

endmodule

// ----- hdl/mfld_checker.sv -----
// Port-level checker for the framebuffer line engine, bound to the top level.
module mfld_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic       rsp_done_res
);

   logic [1:0] pend_ff, pend_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + 2'd1;
      end else if (!req_fire && rsp_fire) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_done_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_done_res)
      else $error("response without done flag");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled response changed");

   a_init_blocks: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without a pending request");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two requests in flight");

endmodule

bind mono_framebuffer_line_draw mfld_checker u_mfld_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_read_data (rsp_if.read_data),
   .rsp_done_res  (rsp_if.done_res)
);

// ----- tb/sv/mono_framebuffer_line_draw_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the monochrome page framebuffer line engine.
module mono_framebuffer_line_draw_tb;
   import mfld_pkg::*;

   localparam int STORE_BYTES   = 1024;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 175;
   // Worst case: every request a full-range line plus the longest
   // gap and stall, ~1750 requests, the power-up clear, taken about four times.
   localparam int CYCLE_LIMIT   = 8_000_000;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;   // unused code, must be a no-op

   // One request as driven, plus an optional typed-in expectation.
   typedef struct packed {
      logic [OP_W-1:0]             op;
      logic signed [COORD_W-1:0]   xs, ys, xe, ye;
      logic                        color;
      logic [ADDR_IN_W-1:0]        addr;
      logic                        known;
      logic [DATA_W-1:0]           want;
   } fb_request_type;

   typedef struct {
      logic [DATA_W-1:0] data;
      logic              done;
      int                seq;
   } fb_reply_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   mfld_req_if req_ch ();
   mfld_rsp_if rsp_ch ();

   mono_framebuffer_line_draw #(
      .STORE_BYTES (STORE_BYTES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow frame: our own copy of the pixel store and the panel registers.
   logic [DATA_W-1:0] frame_mem [STORE_BYTES];
   int fb_width  = 128;
   int fb_height = 64;

   fb_reply_type pending_replies [$];   // expected responses, oldest first
   int  sent_count     = 0;
   int  checked_count  = 0;
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  stall_left     = 0;
   bit  quiet_phase    = 0;          // no gaps and no stalls while set

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < STORE_BYTES; i++) frame_mem[i] = '0;
   end

   // ---------------------------------------------------------------- predictor
   // Walk a Bresenham line, both ends inclusive, painting only pixels that fall
   // on the panel and inside the store.
   function automatic void paint_line(int x0, int y0, int x1, int y1, bit white);
      int dx, dy, sx, sy, err, e2, idx;
      dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
      sx  = (x0 < x1) ? 1 : -1;
      sy  = (y0 < y1) ? 1 : -1;
      err = dx - dy;
      while (1) begin
         if (x0 >= 0 && y0 >= 0 && x0 < fb_width && y0 < fb_height) begin
            idx = x0 + (y0 / 8) * fb_width;
            if (idx < STORE_BYTES) frame_mem[idx][y0 % 8] = white;
         end
         if (x0 == x1 && y0 == y1) break;
         e2 = 2 * err;
         if (e2 > -dy) begin
            err -= dy;
            x0  += sx;
         end
         if (e2 < dx) begin
            err += dx;
            y0  += sy;
         end
      end
   endfunction

   // Update the shadow frame for one request and return the expected read data.
   function automatic logic [DATA_W-1:0] apply_to_frame(fb_request_type r);
      int span;
      logic [DATA_W-1:0] data;
      data = '0;
      case (r.op)
         OP_DRAW: begin
            paint_line(int'($signed(r.xs)), int'($signed(r.ys)),
                       int'($signed(r.xe)), int'($signed(r.ye)), r.color);
         end
         OP_CLEAR: begin
            span = (fb_width * fb_height) / 8;
            if (span > STORE_BYTES) span = STORE_BYTES;
            for (int i = 0; i < span; i++) frame_mem[i] = '0;
         end
         OP_READ: begin
            if (int'(r.addr) < STORE_BYTES) data = frame_mem[r.addr];
         end
         default: ;
      endcase
      return data;
   endfunction

   // ------------------------------------------------------------------ idling
   // Mostly short idle spans, now and then a long one.
   function automatic int idle_span();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int request_gap();
      if (quiet_phase || $urandom_range(0, 99) < 60) return 0;
      return idle_span();
   endfunction

   // --------------------------------------------------------------- stimulus
   // Random request for the current panel setting. Most lines stay near the
   // panel (some crossing its edges) so they are short and hit real pixels;
   // one in ten uses full-range coordinates. Unused fields carry noise.
   function automatic fb_request_type random_request();
      fb_request_type r;
      int pick, xa, ya, span;
      r.op    = OP_DRAW;
      r.xs    = COORD_W'($urandom);
      r.ys    = COORD_W'($urandom);
      r.xe    = COORD_W'($urandom);
      r.ye    = COORD_W'($urandom);
      r.color = 1'($urandom);
      r.addr  = ADDR_IN_W'($urandom);
      r.known = 1'b0;
      r.want  = '0;
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         r.op = OP_DRAW;
         if ($urandom_range(0, 9) != 0) begin
            xa   = int'($urandom_range(0, fb_width + 11)) - 6;
            ya   = int'($urandom_range(0, fb_height + 11)) - 6;
            r.xs = COORD_W'(xa);
            r.ys = COORD_W'(ya);
            if ($urandom_range(0, 1) != 0) begin
               r.xe = COORD_W'(xa + int'($urandom_range(0, 24)) - 12);
               r.ye = COORD_W'(ya + int'($urandom_range(0, 24)) - 12);
            end else begin
               r.xe = COORD_W'(int'($urandom_range(0, fb_width + 11)) - 6);
               r.ye = COORD_W'(int'($urandom_range(0, fb_height + 11)) - 6);
            end
         end
      end else if (pick < 90) begin
         r.op = OP_READ;
         // favor bytes the panel actually covers
         if ($urandom_range(0, 3) != 0) begin
            span = (fb_width * fb_height) / 8;
            if (span > STORE_BYTES) span = STORE_BYTES;
            if (span < 1) span = 1;
            r.addr = ADDR_IN_W'($urandom_range(0, span - 1));
         end
      end else if (pick < 95) begin
         r.op = OP_CLEAR;
      end else begin
         r.op = OP_SPARE;
      end
      return r;
   endfunction

   // Present one request after an optional gap and hold it until accepted.
   // The expectation is formed at acceptance, in acceptance order.
   task automatic issue_request(fb_request_type r, int gap);
      logic [DATA_W-1:0] predicted;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.operation    <= r.op;
      req_ch.x_start      <= r.xs;
      req_ch.y_start      <= r.ys;
      req_ch.x_end        <= r.xe;
      req_ch.y_end        <= r.ye;
      req_ch.color        <= r.color;
      req_ch.byte_address <= r.addr;
      req_ch.valid        <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_to_frame(r);
      pending_replies.push_back('{r.known ? r.want : predicted, 1'b1, sent_count});
      sent_count++;
   endtask

   // Let every outstanding response come back, then idle for the given tail.
   task automatic drain_replies(int tail);
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // Program both panel registers back to back; the spare top bit of the
   // height write is noise that the register must drop.
   task automatic write_panel(int w, int h);
      csr_we    <= 1'b1;
      csr_index <= CSR_PANEL_WIDTH;
      csr_wdata <= w[7:0];
      @(posedge clock);
      csr_index <= CSR_PANEL_HEIGHT;
      csr_wdata <= {1'($urandom), h[6:0]};
      @(posedge clock);
      csr_we    <= 1'b0;
      fb_width  = w & 8'hFF;
      fb_height = h & 7'h7F;
   endtask

   // ----------------------------------------------------------------- checker
   task automatic report_mismatch(string what, int seq, int got, int want);
      $display("MISMATCH %s (request %0d): got 0x%0h, want 0x%0h", what, seq, got, want);
      mismatch_count++;
   endtask

   // Response side: check the handshake seen at this edge, then pick the
   // next ready level (runs of ready, short stalls, the odd long stall).
   always @(posedge clock) begin
      fb_reply_type exp_reply;
      cycle_count++;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("response with no request waiting", -1,
                               int'(rsp_ch.read_data), 0);
            end else begin
               exp_reply = pending_replies.pop_front();
               checked_count++;
               if (rsp_ch.read_data !== exp_reply.data)
                  report_mismatch("read_data", exp_reply.seq,
                                  int'(rsp_ch.read_data), int'(exp_reply.data));
               if (rsp_ch.done_res !== exp_reply.done)
                  report_mismatch("done_res", exp_reply.seq,
                                  int'(rsp_ch.done_res), int'(exp_reply.done));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (quiet_phase || $urandom_range(0, 3) != 0) begin
            rsp_ch.ready <= 1'b1;
            stall_left   = $urandom_range(0, 8);
         end else begin
            rsp_ch.ready <= 1'b0;
            stall_left   = idle_span();
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------- main
   initial begin : stimulus
      fb_request_type plan [$];
      int panel_w_plan [PHASES] = '{128, 1, 0, 255, 37, 100, 16, 64, 0, 0};
      int panel_h_plan [PHASES] = '{64, 8, 64, 127, 20, 8, 64, 0, 0, 0};

      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_PANEL_WIDTH;
      csr_wdata           <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.operation    <= OP_DRAW;
      req_ch.x_start      <= '0;
      req_ch.y_start      <= '0;
      req_ch.x_end        <= '0;
      req_ch.y_end        <= '0;
      req_ch.color        <= 1'b0;
      req_ch.byte_address <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed requests at the reset panel (128 x 64). Typed-in responses
      // where the answer is obvious; the rest go through the shadow frame.
      // Fields: op, xs, ys, xe, ye, color, addr, known, want.
      // store is zero after reset
      plan.push_back('{OP_READ,     0,    0,    0,    0, 1'b0,    0, 1'b1, 8'h00});
      plan.push_back('{OP_READ,     0,    0,    0,    0, 1'b0, 1023, 1'b1, 8'h00});
      // single-pixel lines at the two panel corners
      plan.push_back('{OP_DRAW,     0,    0,    0,    0, 1'b1,    0, 1'b1, 8'h00});
      plan.push_back('{OP_READ,     0,    0,    0,    0, 1'b0,    0, 1'b1, 8'h01});
      plan.push_back('{OP_DRAW,   127,   63,  127,   63, 1'b1,    0, 1'b1, 8'h00});
      plan.push_back('{OP_READ,     0,    0,    0,    0, 1'b0, 1023, 1'b1, 8'h80});
      // full-range diagonals: mostly off panel, walk must carry on
      plan.push_back('{OP_DRAW,  -512, -512,  511,  511, 1'b1,    0, 1'b1, 8'h00});
      plan.push_back('{OP_READ,     0,    0,    0,    0, 1'b0,  137, 1'b0, 8'h00});
      plan.push_back('{OP_DRAW,   511, -512, -512,  511, 1'b0,    0, 1'b1, 8'h00});
      plan.push_back('{OP_READ,     0,    0,    0,    0, 1'b0,  137, 1'b0, 8'h00});
      // horizontal, reversed vertical, steep black line
      plan.push_back('{OP_DRAW,     0,   10,  127,   10, 1'b1,    0, 1'b1, 8'h00});
      plan.push_back('{OP_READ,     0,    0,    0,    0, 1'b0,  133, 1'b0, 8'h00});
      plan.push_back('{OP_DRAW,     5,   63,    5,    0, 1'b1,    0, 1'b1, 8'h00});
      plan.push_back('{OP_READ,     0,    0,    0,    0, 1'b0,  901, 1'b0, 8'h00});
      plan.push_back('{OP_DRAW,   100,   60,   90,    2, 1'b0,    0, 1'b1, 8'h00});
      // column at x == width and row at y == height: both just off the panel
      plan.push_back('{OP_DRAW,   128,    0,  128,   63, 1'b1,    0, 1'b1, 8'h00});
      plan.push_back('{OP_DRAW,     0,   64,  127,   64, 1'b1,    0, 1'b1, 8'h00});
      plan.push_back('{OP_READ,     0,    0,    0,    0, 1'b0,  127, 1'b0, 8'h00});
      // unused operation code changes nothing
      plan.push_back('{OP_SPARE,    0,    0,    0,    0, 1'b0,    0, 1'b1, 8'h00});
      // shallow line entering from negative coordinates
      plan.push_back('{OP_DRAW,    -3,   -7,   20,    4, 1'b1,    0, 1'b1, 8'h00});
      plan.push_back('{OP_READ,     0,    0,    0,    0, 1'b0,   20, 1'b0, 8'h00});
      // full clear at 128 x 64 covers the whole store
      plan.push_back('{OP_CLEAR,    0,    0,    0,    0, 1'b0,    0, 1'b1, 8'h00});
      plan.push_back('{OP_READ,     0,    0,    0,    0, 1'b0,    0, 1'b1, 8'h00});
      plan.push_back('{OP_READ,     0,    0,    0,    0, 1'b0, 1023, 1'b1, 8'h00});

      foreach (plan[i]) issue_request(plan[i], request_gap());

      // Random phases, each under its own panel setting: the extremes, zero
      // width, a zero height, sizes past the store, odd sizes, two random ones.
      // Two of the phases run with no gaps and no stalls at all.
      for (int p = 0; p < PHASES; p++) begin
         drain_replies(4);
         if (p >= 8) begin
            panel_w_plan[p] = $urandom_range(1, 128);
            panel_h_plan[p] = $urandom_range(8, 64);
         end
         write_panel(panel_w_plan[p], panel_h_plan[p]);
         quiet_phase = (p == 2 || p == 6);
         for (int n = 0; n < PHASE_ITEMS; n++) issue_request(random_request(), request_gap());
      end

      quiet_phase = 1'b0;
      drain_replies(32);
      $display("Drove %0d requests across %0d panel settings; %0d responses checked.",
               sent_count, PHASES + 1, checked_count);
      $display("Lines, clears, reads and the unused code, with gaps and stalls on both sides.");
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
